// File: design/cnh_pkg.sv
// Shared types, constants and the arctangent table for the compass heading block.
// No dependencies; used by every module in this folder.
`timescale 1ns / 1ps

package cnh_pkg;

   localparam int SMP_W            = 16;
   localparam int HEAD_W           = 15;
   localparam int NUM_W            = 19;
   localparam int DEN_W            = 17;
   localparam int REM_W            = 32;
   localparam int QUO_W            = 16;
   localparam int XY_W             = 20;
   localparam int ACC_W            = 24;
   localparam int H_W              = 25;
   localparam int ATAN_MAX         = 24;
   localparam int DEF_ANGLE_STAGES = 16;
   localparam int DEG_UNIT         = 16384;
   localparam int NUM_AXES         = 3;
   localparam int NUM_REGS         = 6;
   localparam int CSR_ADDR_W       = 5;
   localparam int HEAD_FULL        = 23040;

   typedef enum logic [2:0] {
      REG_X_HIGH = 3'd0,
      REG_Y_HIGH = 3'd1,
      REG_Z_HIGH = 3'd2,
      REG_X_LOW  = 3'd3,
      REG_Y_LOW  = 3'd4,
      REG_Z_LOW  = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             zero;
   } div_type;

   typedef struct packed {
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [ACC_W-1:0] acc;
      logic                    zv;
      logic [SMP_W-1:0]        xn;
      logic [SMP_W-1:0]        yn;
      logic [SMP_W-1:0]        zn;
   } cordic_type;

   // atan(2^-i) in 1/16384 degree
   function automatic logic signed [ACC_W-1:0] atan_lut(input int idx);
      logic signed [ACC_W-1:0] r;
      r = '0;
      case (idx)
         0:  r = 24'sd737280;
         1:  r = 24'sd435242;
         2:  r = 24'sd229970;
         3:  r = 24'sd116736;
         4:  r = 24'sd58595;
         5:  r = 24'sd29326;
         6:  r = 24'sd14667;
         7:  r = 24'sd7334;
         8:  r = 24'sd3667;
         9:  r = 24'sd1833;
         10: r = 24'sd917;
         11: r = 24'sd458;
         12: r = 24'sd229;
         13: r = 24'sd115;
         14: r = 24'sd57;
         15: r = 24'sd29;
         16: r = 24'sd14;
         17: r = 24'sd7;
         18: r = 24'sd4;
         19: r = 24'sd2;
         20: r = 24'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// File: design/cnh_div_cell.sv
// One restoring-division cell: decides one quotient bit of one axis.
// Depends on cnh_pkg.
`timescale 1ns / 1ps

module cnh_div_cell #(
   parameter int SHIFT = 0
) (
   input  logic             clock,
   input  logic             en,
   input  cnh_pkg::div_type d_in,
   output cnh_pkg::div_type d_out
);
   import cnh_pkg::*;

   logic [REM_W:0] dsh;
   logic [REM_W:0] trial;
   logic           take;
   div_type        d_in_c;
   div_type        d_ff;

   always_comb begin
      dsh   = (REM_W+1)'(d_in.den) << SHIFT;
      trial = {1'b0, d_in.rem} - dsh;
      take  = !trial[REM_W];
      d_in_c      = d_in;
      d_in_c.rem  = take ? trial[REM_W-1:0] : d_in.rem;
      d_in_c.quo  = {d_in.quo[QUO_W-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in_c;
      end
   end

   assign d_out = d_ff;
endmodule

// File: design/cnh_cordic_cell.sv
// One vectoring micro-rotation of the heading CORDIC.
// Depends on cnh_pkg (state type and arctangent table).
`timescale 1ns / 1ps

module cnh_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                clock,
   input  logic                en,
   input  cnh_pkg::cordic_type c_in,
   output cnh_pkg::cordic_type c_out
);
   import cnh_pkg::*;

   localparam logic signed [ACC_W-1:0] ANG = atan_lut(IDX);

   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;
   cordic_type             c_in_c;
   cordic_type             c_ff;

   always_comb begin
      dx     = c_in.y >>> IDX;
      dy     = c_in.x >>> IDX;
      c_in_c = c_in;
      if (!c_in.zv) begin
         if (!c_in.y[XY_W-1]) begin
            c_in_c.x   = c_in.x + dx;
            c_in_c.y   = c_in.y - dy;
            c_in_c.acc = c_in.acc + ANG;
         end else begin
            c_in_c.x   = c_in.x - dx;
            c_in_c.y   = c_in.y + dy;
            c_in_c.acc = c_in.acc - ANG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff <= c_in_c;
      end
   end

   assign c_out = c_ff;
endmodule

// File: design/compass_axis_normalize_heading.sv
// Top level: calibration registers, axis normalizer and heading pipeline.
// Depends on cnh_pkg, cnh_div_cell, cnh_cordic_cell.
//
//   channel | direction | payload
//   req_    | in        | tdata: x_sample, y_sample, z_sample (16b each)
//   rsp_    | out       | tdata: x_norm, y_norm, z_norm (16b), heading (15b), pad
//   csr_    | in/out    | APB, six 16b calibration registers at 4*i
//
// One beat per cycle is taken sustained while the receiver keeps rsp_tready high.
// Depth is set by 16 division cells per axis and one CORDIC cell per stage.
// Each stage holds its beat only while the one after it is full and stalled.
// Synchronous reset clears the valid bits and the calibration registers.
`timescale 1ns / 1ps

module compass_axis_normalize_heading #(
   parameter int ANGLE_STAGES = cnh_pkg::DEF_ANGLE_STAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // x_sample, y_sample, z_sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // x_norm, y_norm, z_norm, heading, zero pad
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [cnh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cnh_pkg::*;

   localparam int NA = (ANGLE_STAGES > ATAN_MAX) ? ATAN_MAX : ANGLE_STAGES;
   localparam int ST_DIV = 2;
   localparam int ST_SAT = ST_DIV + QUO_W;
   localparam int ST_ROT = ST_SAT + 1;
   localparam int ST_COR = ST_ROT + 1;
   localparam int ST_OUT = ST_COR + NA;
   localparam int NS     = ST_OUT + 1;
   localparam logic signed [H_W-1:0] H450 = H_W'(450 * DEG_UNIT);
   localparam logic signed [H_W-1:0] H360 = H_W'(360 * DEG_UNIT);
   localparam logic signed [ACC_W-1:0] A90 = ACC_W'(90 * DEG_UNIT);

   // configuration
   logic [SMP_W-1:0] cal_ff [NUM_REGS];
   csr_reg_type      csr_idx;
   logic             csr_wr;

   assign csr_idx    = csr_reg_type'(csr_paddr[4:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            cal_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_X_HIGH: cal_ff[0] <= csr_pwdata[SMP_W-1:0];
            REG_Y_HIGH: cal_ff[1] <= csr_pwdata[SMP_W-1:0];
            REG_Z_HIGH: cal_ff[2] <= csr_pwdata[SMP_W-1:0];
            REG_X_LOW:  cal_ff[3] <= csr_pwdata[SMP_W-1:0];
            REG_Y_LOW:  cal_ff[4] <= csr_pwdata[SMP_W-1:0];
            REG_Z_LOW:  cal_ff[5] <= csr_pwdata[SMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_idx)
         REG_X_HIGH: csr_prdata = {{16{cal_ff[0][15]}}, cal_ff[0]};
         REG_Y_HIGH: csr_prdata = {{16{cal_ff[1][15]}}, cal_ff[1]};
         REG_Z_HIGH: csr_prdata = {{16{cal_ff[2][15]}}, cal_ff[2]};
         REG_X_LOW:  csr_prdata = {{16{cal_ff[3][15]}}, cal_ff[3]};
         REG_Y_LOW:  csr_prdata = {{16{cal_ff[4][15]}}, cal_ff[4]};
         REG_Z_LOW:  csr_prdata = {{16{cal_ff[5][15]}}, cal_ff[5]};
         default:    csr_prdata = '0;
      endcase
   end

   // valid chain with bubble collapse
   logic [NS-1:0] v_ff;
   logic [NS:0]   adv;

   assign adv[NS] = rsp_tready;
   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_vld
         assign adv[k] = !v_ff[k] || adv[k+1];
         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (adv[k]) begin
               v_ff[k] <= (k == 0) ? req_tvalid : v_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   endgenerate

   assign req_tready = adv[0];
   assign rsp_tvalid = v_ff[NS-1];

   // stage 0: numerator and denominator
   logic signed [NUM_W-1:0] num_ff [NUM_AXES];
   logic signed [DEN_W-1:0] den_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            num_ff[a] <= ({{3{req_tdata[a*SMP_W+15]}}, req_tdata[a*SMP_W +: SMP_W]} <<< 1)
               - ({{3{cal_ff[a][15]}}, cal_ff[a]} + {{3{cal_ff[a+3][15]}}, cal_ff[a+3]});
            den_ff[a] <= {cal_ff[a][15], cal_ff[a]} - {cal_ff[a+3][15], cal_ff[a+3]};
         end
      end
   end

   // stage 1: magnitudes, scaled dividend
   div_type div_s [QUO_W+1][NUM_AXES];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            logic [NUM_W-1:0] an;
            logic [DEN_W-1:0] ad;
            an = num_ff[a][NUM_W-1] ? NUM_W'(-num_ff[a]) : NUM_W'(num_ff[a]);
            ad = den_ff[a][DEN_W-1] ? DEN_W'(-den_ff[a]) : DEN_W'(den_ff[a]);
            div_s[0][a].rem  <= (REM_W'(an[16:0]) << 14) + REM_W'(ad[15:0]);
            div_s[0][a].den  <= {ad[15:0], 1'b0};
            div_s[0][a].quo  <= '0;
            div_s[0][a].neg  <= num_ff[a][NUM_W-1] ^ den_ff[a][DEN_W-1];
            div_s[0][a].zero <= (den_ff[a] == '0);
         end
      end
   end

   genvar j, ax;
   generate
      for (j = 0; j < QUO_W; j++) begin : g_div
         for (ax = 0; ax < NUM_AXES; ax++) begin : g_ax
            cnh_div_cell #(.SHIFT(QUO_W-1-j)) u_cell (
               .clock (clock),
               .en    (adv[ST_DIV+j]),
               .d_in  (div_s[j][ax]),
               .d_out (div_s[j+1][ax])
            );
         end
      end
   endgenerate

   // saturation; top quotient bit flags a magnitude of 2^15 or more
   logic [SMP_W-1:0] norm_ff [NUM_AXES];

   always_ff @(posedge clock) begin
      if (adv[ST_SAT]) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            div_type dq;
            dq = div_s[QUO_W][a];
            if (dq.zero) begin
               norm_ff[a] <= '0;
            end else if (dq.quo[QUO_W-1]) begin
               norm_ff[a] <= dq.neg ? 16'h8000 : 16'h7FFF;
            end else if (dq.neg) begin
               norm_ff[a] <= SMP_W'(-{1'b0, dq.quo[QUO_W-2:0]});
            end else begin
               norm_ff[a] <= {1'b0, dq.quo[QUO_W-2:0]};
            end
         end
      end
   end

   // quadrant pre-rotation
   cordic_type cor_s [NA+1];

   always_ff @(posedge clock) begin
      if (adv[ST_ROT]) begin
         logic signed [XY_W-1:0] xs;
         logic signed [XY_W-1:0] ys;
         xs = {{(XY_W-SMP_W){norm_ff[0][15]}}, norm_ff[0]};
         ys = {{(XY_W-SMP_W){norm_ff[1][15]}}, norm_ff[1]};
         cor_s[0].xn <= norm_ff[0];
         cor_s[0].yn <= norm_ff[1];
         cor_s[0].zn <= norm_ff[2];
         cor_s[0].zv <= (norm_ff[0] == '0) && (norm_ff[1] == '0);
         if (!xs[XY_W-1]) begin
            cor_s[0].x   <= xs;
            cor_s[0].y   <= ys;
            cor_s[0].acc <= '0;
         end else if (!ys[XY_W-1]) begin
            cor_s[0].x   <= ys;
            cor_s[0].y   <= -xs;
            cor_s[0].acc <= A90;
         end else begin
            cor_s[0].x   <= -ys;
            cor_s[0].y   <= xs;
            cor_s[0].acc <= -A90;
         end
      end
   end

   genvar c;
   generate
      for (c = 0; c < NA; c++) begin : g_cor
         cnh_cordic_cell #(.IDX(c)) u_cell (
            .clock (clock),
            .en    (adv[ST_COR+c]),
            .c_in  (cor_s[c]),
            .c_out (cor_s[c+1])
         );
      end
   endgenerate

   // compass mapping and rounding
   logic signed [H_W-1:0] h_raw;
   logic signed [H_W-1:0] h_mod;
   logic [H_W-1:0]        h_rnd;
   logic [HEAD_W-1:0]     head_c;
   logic [63:0]           rsp_ff;

   always_comb begin
      h_raw  = H450 - {cor_s[NA].acc[ACC_W-1], cor_s[NA].acc};
      h_mod  = (h_raw >= H360) ? h_raw - H360 : h_raw;
      h_rnd  = (H_W'(h_mod) + H_W'(128)) >> 8;
      head_c = (h_rnd >= H_W'(HEAD_FULL)) ? '0 : h_rnd[HEAD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         rsp_ff <= {1'b0, head_c, cor_s[NA].zn, cor_s[NA].yn, cor_s[NA].xn};
      end
   end

   assign rsp_tdata = rsp_ff;

`ifndef SYNTHESIS
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[62:48] < 15'd23040))
      else $error("heading out of range");

   a_zero_vec: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[15:0] == 16'd0 && rsp_tdata[31:16] == 16'd0)
         |-> (rsp_tdata[62:48] == 15'd5760))
      else $error("zero vector heading not 90 degrees");

   a_take: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted beat lost at first stage");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[63])
      else $error("pad bit set");
`endif

endmodule

// File: bench/tb_compass_axis_normalize_heading.sv
// Testbench for compass_axis_normalize_heading: random and directed samples
// against a built-in calibrated normalizer and CORDIC heading predictor.
// Depends on cnh_pkg and the design sources.
`timescale 1ns / 1ps

class heading_scoreboard;
   logic [15:0] cal[6];
   logic [63:0] pending[$];
   int          errors;
   int          checked;

   function new();
      errors  = 0;
      checked = 0;
      foreach (cal[i]) cal[i] = '0;
   endfunction

   function automatic int norm_axis(int s, int hi, int lo);
      longint num, den, an, ad, q;
      if (hi == lo) return 0;
      num = 2 * longint'(s) - (longint'(hi) + longint'(lo));
      den = longint'(hi) - longint'(lo);
      an  = num < 0 ? -num : num;
      ad  = den < 0 ? -den : den;
      q   = (an * 16384 + ad) / (2 * ad);
      if ((num < 0) != (den < 0)) q = -q;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return int'(q);
   endfunction

   function automatic longint atan_step(int i);
      longint t[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                        3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
      return t[i];
   endfunction

   function automatic int compass_heading(int xn, int yn);
      longint x, y, acc, t, h, dx, dy;
      x   = xn;
      y   = yn;
      acc = 0;
      if (xn != 0 || yn != 0) begin
         if (x < 0) begin
            if (y >= 0) begin
               t = x; x = y; y = -t; acc = 90 * 16384;
            end else begin
               t = x; x = -y; y = t; acc = -90 * 16384;
            end
         end
         for (int i = 0; i < cnh_pkg::DEF_ANGLE_STAGES && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x = x + dx; y = y - dy; acc += atan_step(i);
            end else begin
               x = x - dx; y = y + dy; acc -= atan_step(i);
            end
         end
      end
      h = 450 * 16384 - acc;
      while (h >= 360 * 16384) h -= 360 * 16384;
      while (h < 0) h += 360 * 16384;
      h = (h + 128) >>> 8;
      if (h >= 23040) h = 0;
      return int'(h);
   endfunction

   function void note_sample(logic [47:0] d);
      int n[3];
      for (int a = 0; a < 3; a++)
         n[a] = norm_axis(int'($signed(d[16*a +: 16])), int'($signed(cal[a])),
                          int'($signed(cal[a+3])));
      pending.push_back({1'b0, 15'(compass_heading(n[0], n[1])),
                         16'(n[2]), 16'(n[1]), 16'(n[0])});
   endfunction

   function void check_result(logic [63:0] d);
      logic [63:0] e;
      string       names[4] = '{"x_norm", "y_norm", "z_norm", "heading"};
      checked++;
      if (pending.size() == 0) begin
         $error("result beat with nothing expected: %h", d);
         errors++;
         return;
      end
      e = pending.pop_front();
      for (int f = 0; f < 4; f++) begin
         if (f < 3 && e[16*f +: 16] !== d[16*f +: 16]) begin
            $error("%s expected %0d actual %0d", names[f],
                   $signed(e[16*f +: 16]), $signed(d[16*f +: 16]));
            errors++;
         end
      end
      if (e[62:48] !== d[62:48]) begin
         $error("heading expected %0d actual %0d", e[62:48], d[62:48]);
         errors++;
      end
      if (d[63] !== 1'b0) begin
         $error("pad expected 0 actual %0d", d[63]);
         errors++;
      end
   endfunction
endclass

module tb_compass_axis_normalize_heading;
   import cnh_pkg::*;

   localparam int LATENCY  = 21 + DEF_ANGLE_STAGES;
   localparam int WATCHDOG = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   heading_scoreboard sb;
   int  idle_cycles;
   int  samples_sent;
   bit  calm;
   bit  long_hold;
   bit  timed_out;

   compass_axis_normalize_heading dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
                   || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (!reset && idle_cycles >= WATCHDOG && !timed_out) begin
         timed_out = 1'b1;
         $display("compass_axis_normalize_heading verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (!reset && req_tvalid && req_tready) sb.note_sample(req_tdata);
   end

   // receiver: random stall bursts, one long hold-off, none when calm
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (150) @(posedge clock);
            long_hold = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 15);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(csr_reg_type r, logic [15:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(r));
      csr_pwdata  <= {{16{v[15]}}, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.cal[int'(r)] = v;
   endtask

   task automatic load_cal(logic [15:0] xh, logic [15:0] yh, logic [15:0] zh,
                           logic [15:0] xl, logic [15:0] yl, logic [15:0] zl);
      csr_write(REG_X_HIGH, xh);
      csr_write(REG_Y_HIGH, yh);
      csr_write(REG_Z_HIGH, zh);
      csr_write(REG_X_LOW, xl);
      csr_write(REG_Y_LOW, yl);
      csr_write(REG_Z_LOW, zl);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      int n;
      if (!calm && $urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, 15);
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [15:0] near(logic [15:0] hi, logic [15:0] lo);
      int h, l;
      h = int'($signed(hi));
      l = int'($signed(lo));
      if (h < l) begin
         int t = h; h = l; l = t;
      end
      return 16'($urandom_range(0, h - l + 2000) + l - 1000);
   endfunction

   task automatic random_phase(int count, logic [15:0] xh, logic [15:0] yh,
                               logic [15:0] zh, logic [15:0] xl, logic [15:0] yl,
                               logic [15:0] zl);
      load_cal(xh, yh, zh, xl, yl, zl);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom));
         else
            send_sample(near(xh, xl), near(yh, yl), near(zh, zl));
      end
      drain();
   endtask

   initial begin
      logic [15:0] c[6];
      sb          = new();
      timed_out   = 1'b0;
      calm        = 1'b0;
      long_hold   = 1'b0;
      samples_sent = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: every axis collapses to zero, heading 90 degrees
      send_sample(16'h7fff, 16'h8000, 16'h1234);
      send_sample(16'h0000, 16'h0000, 16'h0000);
      drain();

      // full scale calibration, extremes and all quadrants
      load_cal(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7fff, 16'h7fff, 16'h7fff);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'hffff, 16'hffff, 16'hffff);
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h4000, 16'h0000, 16'h0000);
      send_sample(16'hc000, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'h4000, 16'h0000);
      send_sample(16'h0000, 16'hc000, 16'h0000);
      send_sample(16'hc000, 16'h4000, 16'h5555);
      send_sample(16'hc000, 16'hc000, 16'haaaa);
      send_sample(16'h4000, 16'hc000, 16'h0001);
      drain();

      // narrow window saturates; inverted window flips sign; equal bounds give zero
      load_cal(16'd10, 16'hfff6, 16'd5, 16'd0, 16'd10, 16'd5);
      send_sample(16'h7fff, 16'h8000, 16'h7fff);
      send_sample(16'h8000, 16'h7fff, 16'h8000);
      send_sample(16'd5, 16'd0, 16'd5);
      send_sample(16'd7, 16'd3, 16'd0);
      drain();

      // long receiver hold-off while samples are sent, then a sender pause until all results are back
      load_cal(16'd600, 16'd500, 16'd400, 16'hfe00, 16'hfd00, 16'hfc00);
      long_hold = 1'b1;
      for (int i = 0; i < 120; i++)
         send_sample(16'($urandom), 16'($urandom), 16'($urandom));
      drain();

      for (int p = 0; p < 6; p++) begin
         for (int k = 0; k < 6; k++) c[k] = 16'($urandom);
         if (p == 1) c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000};
         if (p == 2) c[0] = c[3];
         random_phase(270, c[0], c[1], c[2], c[3], c[4], c[5]);
      end
      calm = 1'b1;
      random_phase(150, 16'd3000, 16'hf000, 16'd100, 16'hf800, 16'h1000, 16'hff00);

      $display("Covered %0d samples over several calibration sets, %0d results checked.",
               samples_sent, sb.checked);
      if (sb.errors == 0)
         $display("compass_axis_normalize_heading verification clean");
      else
         $display("compass_axis_normalize_heading verification failed");
      $finish;
   end
endmodule

// File: compass_axis_normalize_heading.f
design/cnh_pkg.sv
design/cnh_div_cell.sv
design/cnh_cordic_cell.sv
design/compass_axis_normalize_heading.sv
bench/tb_compass_axis_normalize_heading.sv
